// ----- rtl/button_debounce_long_press_assert.svh -----
// Assertion macros shared by the button poller RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BDLP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bdlp_pkg.sv -----
// Shared constants, types and codes of the button poller.
// No dependencies; used by every module of the block.
package bdlp_pkg;

	localparam int EXP_BUTTONS = 8;
	localparam int DIR_BUTTONS = 4;
	localparam int TIME_W      = 32;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int KIND_W      = 2;

	localparam int NUM_IDS    = EXP_BUTTONS + DIR_BUTTONS;
	localparam int ID_W       = $clog2(NUM_IDS);
	localparam int EXP_IDX_W  = (EXP_BUTTONS > 1) ? $clog2(EXP_BUTTONS) : 1;
	localparam int DIR_IDX_W  = (DIR_BUTTONS > 1) ? $clog2(DIR_BUTTONS) : 1;
	localparam int IN_TDATA_W = ((EXP_BUTTONS + DIR_BUTTONS + TIME_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((ID_W + TIME_W + 7) / 8) * 8;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = CFG_W'(50);
	localparam logic [CFG_W-1:0] LONG_PRESS_RESET = CFG_W'(1000);

	typedef enum logic [KIND_W-1:0] {
		KIND_PRESS   = 2'd0,
		KIND_LONG    = 2'd1,
		KIND_RELEASE = 2'd2
	} bdlp_kind_t;

	// One direct button's debouncer state, one memory word.
	typedef struct packed {
		logic              raw_level;
		logic              held;
		logic              long_sent;
		logic [TIME_W-1:0] change_time;
		logic [TIME_W-1:0] press_time;
	} bdlp_entry_t;

	localparam bdlp_entry_t ENTRY_RESET = '{
		raw_level:   1'b1,
		held:        1'b0,
		long_sent:   1'b0,
		change_time: '0,
		press_time:  '0
	};

	// Everything one poll reports, handed from the poll engine to the emitter.
	typedef struct packed {
		logic [EXP_BUTTONS-1:0]             exp_ev;
		logic [EXP_BUTTONS-1:0]             exp_cur;
		logic [DIR_BUTTONS-1:0]             dir_ev;
		logic [DIR_BUTTONS-1:0][KIND_W-1:0] dir_kind;
		logic [TIME_W-1:0]                  poll_time;
	} bdlp_summary_t;

endpackage

// ----- rtl/bdlp_state_mem.sv -----
// Debouncer state memory: one word per direct button, registered read.
// Depends on bdlp_pkg; unwritten words read as the reset state.
module bdlp_state_mem (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 rd_en,
	input  logic [bdlp_pkg::DIR_IDX_W-1:0]       rd_addr,
	output bdlp_pkg::bdlp_entry_t                rd_data,
	input  logic                                 wr_en,
	input  logic [bdlp_pkg::DIR_IDX_W-1:0]       wr_addr,
	input  bdlp_pkg::bdlp_entry_t                wr_data
);
	import bdlp_pkg::*;

	bdlp_entry_t            mem_q [DIR_BUTTONS];
	logic [DIR_BUTTONS-1:0] valid_q;
	bdlp_entry_t            rd_word_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_word_q : ENTRY_RESET;

`include "button_debounce_long_press_assert.svh"

	// Write-back always comes in the cycle after the read of the same word.
	`BDLP_ASSERT_NOW(a_no_rw_clash, clk, arst_n, wr_en && rd_en, wr_addr != rd_addr, "state memory read and write hit the same word")

endmodule

// ----- rtl/bdlp_poll_engine.sv -----
// Poll engine: expander diff plus read-modify-write of each direct debouncer.
// Depends on bdlp_pkg and bdlp_state_mem; hands a poll summary to the emitter.
module bdlp_poll_engine (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic                                  expander_present,
	input  logic [bdlp_pkg::EXP_BUTTONS-1:0]      expander_mask,
	input  logic [bdlp_pkg::DIR_BUTTONS-1:0]      direct_levels,
	input  logic [bdlp_pkg::TIME_W-1:0]           now_ms,
	input  logic [bdlp_pkg::CFG_W-1:0]            debounce_time,
	input  logic [bdlp_pkg::CFG_W-1:0]            long_press_time,
	output logic                                  idle,
	output logic                                  hand_valid,
	output bdlp_pkg::bdlp_summary_t               hand,
	input  logic                                  hand_take
);
	import bdlp_pkg::*;

	localparam logic [DIR_IDX_W-1:0] LAST_IDX = DIR_IDX_W'(DIR_BUTTONS - 1);

	logic [EXP_BUTTONS-1:0] prev_exp_q;
	logic [DIR_BUTTONS-1:0] lev_q;
	logic                   run_q;
	logic [DIR_IDX_W-1:0]   rd_idx_q;
	logic                   vld_s1;
	logic [DIR_IDX_W-1:0]   idx_s1;
	bdlp_summary_t          sum_q;
	logic                   hand_valid_q;

	bdlp_entry_t       ent;
	bdlp_entry_t       nxt;
	logic              level;
	logic [TIME_W-1:0] since_change;
	logic [TIME_W-1:0] since_press;
	logic              ev;
	bdlp_kind_t        ev_kind;

	bdlp_state_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (run_q),
		.rd_addr (rd_idx_q),
		.rd_data (ent),
		.wr_en   (vld_s1),
		.wr_addr (idx_s1),
		.wr_data (nxt)
	);

	// Debounce and long-press decision for the word just read.
	always_comb begin
		nxt          = ent;
		ev           = 1'b0;
		ev_kind      = KIND_PRESS;
		level        = lev_q[idx_s1];
		since_change = sum_q.poll_time - ent.change_time;
		since_press  = sum_q.poll_time - ent.press_time;
		if (level != ent.raw_level) begin
			nxt.raw_level   = level;
			nxt.change_time = sum_q.poll_time;
		end else if (since_change >= TIME_W'(debounce_time)) begin
			if (!level && !ent.held) begin
				nxt.held       = 1'b1;
				nxt.press_time = sum_q.poll_time;
				nxt.long_sent  = 1'b0;
				ev             = 1'b1;
				ev_kind        = KIND_PRESS;
			end else if (!level && ent.held && !ent.long_sent) begin
				if (since_press >= TIME_W'(long_press_time)) begin
					nxt.long_sent = 1'b1;
					ev            = 1'b1;
					ev_kind       = KIND_LONG;
				end
			end else if (level && ent.held) begin
				nxt.held = 1'b0;
				ev       = 1'b1;
				ev_kind  = KIND_RELEASE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			lev_q           <= direct_levels;
			sum_q.poll_time <= now_ms;
			sum_q.exp_cur   <= expander_mask;
			sum_q.exp_ev    <= expander_present ? (expander_mask ^ prev_exp_q) : '0;
			sum_q.dir_ev    <= '0;
			sum_q.dir_kind  <= '0;
		end else if (vld_s1) begin
			sum_q.dir_ev[idx_s1]   <= ev;
			sum_q.dir_kind[idx_s1] <= ev_kind;
		end
		idx_s1 <= rd_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_exp_q   <= '0;
			run_q        <= 1'b0;
			rd_idx_q     <= '0;
			vld_s1       <= 1'b0;
			hand_valid_q <= 1'b0;
		end else begin
			vld_s1 <= run_q;
			if (start) begin
				run_q    <= 1'b1;
				rd_idx_q <= '0;
				if (expander_present) begin
					prev_exp_q <= expander_mask;
				end
			end else if (run_q) begin
				rd_idx_q <= rd_idx_q + DIR_IDX_W'(1);
				if (rd_idx_q == LAST_IDX) begin
					run_q <= 1'b0;
				end
			end
			if (vld_s1 && idx_s1 == LAST_IDX) begin
				hand_valid_q <= 1'b1;
			end else if (hand_take) begin
				hand_valid_q <= 1'b0;
			end
		end
	end

	assign idle       = !run_q && !vld_s1 && !hand_valid_q;
	assign hand_valid = hand_valid_q;
	assign hand       = sum_q;

`include "button_debounce_long_press_assert.svh"

	`BDLP_ASSERT_NEXT(a_poll_handoff, clk, arst_n, vld_s1 && idx_s1 == LAST_IDX, hand_valid_q, "finished poll not handed off")
	`BDLP_ASSERT_NOW(a_no_start_busy, clk, arst_n, start, !run_q && !vld_s1 && !hand_valid_q, "poll started while engine busy")

endmodule

// ----- rtl/bdlp_emitter.sv -----
// Event emitter: serializes one poll summary into events, lowest id first.
// Depends on bdlp_pkg; drives the registered result channel.
module bdlp_emitter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               hand_valid,
	input  bdlp_pkg::bdlp_summary_t            hand,
	output logic                               hand_take,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic                               m_tlast,
	output logic [bdlp_pkg::KIND_W-1:0]        m_kind,
	output logic [bdlp_pkg::ID_W-1:0]          m_id,
	output logic [bdlp_pkg::TIME_W-1:0]        m_time
);
	import bdlp_pkg::*;

	logic [NUM_IDS-1:0]                 pending_q;
	logic [EXP_BUTTONS-1:0]             cur_q;
	logic [DIR_BUTTONS-1:0][KIND_W-1:0] kinds_q;
	logic [TIME_W-1:0]                  time_q;

	logic                  m_tvalid_q;
	logic                  m_tlast_q;
	logic [KIND_W-1:0]     m_kind_q;
	logic [ID_W-1:0]       m_id_q;
	logic [TIME_W-1:0]     m_time_q;

	logic                  pop;
	logic [ID_W-1:0]       sel;
	logic [DIR_IDX_W-1:0]  dsel;
	logic [NUM_IDS-1:0]    rest;
	bdlp_kind_t            kind;

	assign hand_take = hand_valid && (pending_q == '0);
	assign pop       = (pending_q != '0) && (!m_tvalid_q || m_tready);

	// Pick the lowest pending id and its event kind.
	always_comb begin
		sel = '0;
		for (int i = NUM_IDS - 1; i >= 0; i--) begin
			if (pending_q[i]) begin
				sel = ID_W'(i);
			end
		end
		rest      = pending_q;
		rest[sel] = 1'b0;
		dsel      = DIR_IDX_W'(sel - ID_W'(EXP_BUTTONS));
		if (sel < ID_W'(EXP_BUTTONS)) begin
			kind = cur_q[sel[EXP_IDX_W-1:0]] ? KIND_PRESS : KIND_RELEASE;
		end else begin
			kind = bdlp_kind_t'(kinds_q[dsel]);
		end
	end

	always_ff @(posedge clk) begin
		if (hand_take) begin
			cur_q   <= hand.exp_cur;
			kinds_q <= hand.dir_kind;
			time_q  <= hand.poll_time;
		end
		if (pop) begin
			m_tlast_q <= (rest == '0);
			m_kind_q  <= kind;
			m_id_q    <= sel;
			m_time_q  <= time_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (hand_take) begin
				pending_q <= {hand.dir_ev, hand.exp_ev};
			end else if (pop) begin
				pending_q <= rest;
			end
			if (pop) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_kind   = m_kind_q;
	assign m_id     = m_id_q;
	assign m_time   = m_time_q;

`include "button_debounce_long_press_assert.svh"

	// Events of one poll leave without gaps.
	`BDLP_ASSERT_NEXT(a_no_gap_in_poll, clk, arst_n, m_tvalid_q && m_tready && !m_tlast_q, m_tvalid_q, "gap inside a poll's events")
	`BDLP_ASSERT_NOW(a_take_when_empty, clk, arst_n, pending_q != '0, !hand_take, "summary taken over pending events")

endmodule

// ----- rtl/button_debounce_long_press.sv -----
// Button poller top level: input buffer, configuration registers, poll
// engine and event emitter. Depends on bdlp_pkg, bdlp_poll_engine, bdlp_emitter.
//
// Each transfer on the s_ side is one poll: the expander's pressed mask (used
// only when s_tuser is set), the four active-low direct button levels and the
// current millisecond time. Every expander bit that differs from the last
// polled mask gives a press or release event, bits 0 upward. Each direct button
// (enter, escape, left, right = ids 8..11) runs a debouncer: a level change
// restarts its timer, a level stable for debounce_time gives a press or
// release, and a press held for long_press_time gives one long press. Time
// differences wrap modulo 2^32. Events leave on the m_ side in that order, one
// transfer each, with m_tlast on the final event of the poll; a poll with no
// events produces no transfer. The debouncer state lives in a four-word memory
// that the poll engine reads, updates and writes back one button per cycle;
// the finished poll's summary then goes to the emitter, which loads it and
// sends one event per cycle while m_tready is high. One poll waits in the
// input buffer while another is at work, and the emitter's output register
// keeps a stalled event apart from the engine. No clearing pass is needed
// after reset. Write configuration only while no poll is in flight; unknown
// indexes are dropped.
module button_debounce_long_press (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// poll channel
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [7:0] expander_mask, [11:8] direct_levels, [43:12] now_ms, rest zero
	input  logic [bdlp_pkg::IN_TDATA_W-1:0]       s_tdata,
	// [0] expander_present
	input  logic                                  s_tuser,
	// event channel
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [3:0] button_id, [35:4] event_time, rest zero
	output logic [bdlp_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// [1:0] event_kind
	output logic [bdlp_pkg::KIND_W-1:0]           m_tuser,
	// last_event
	output logic                                  m_tlast,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bdlp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bdlp_pkg::CFG_W-1:0]            cfg_data
);
	import bdlp_pkg::*;

	localparam int LEV_LO = EXP_BUTTONS;
	localparam int NOW_LO = EXP_BUTTONS + DIR_BUTTONS;

	logic [CFG_W-1:0] debounce_q;
	logic [CFG_W-1:0] long_press_q;

	// Input buffer holding the next poll.
	logic                   ibuf_valid_q;
	logic                   ibuf_present_q;
	logic [EXP_BUTTONS-1:0] ibuf_mask_q;
	logic [DIR_BUTTONS-1:0] ibuf_levels_q;
	logic [TIME_W-1:0]      ibuf_now_q;

	logic          eng_idle;
	logic          start;
	logic          hand_valid;
	logic          hand_take;
	bdlp_summary_t hand;

	logic [ID_W-1:0]   ev_id;
	logic [TIME_W-1:0] ev_time;

	assign start     = ibuf_valid_q && eng_idle;
	assign s_tready  = !ibuf_valid_q || start;
	assign cfg_ready = 1'b1;

	// Capture a poll; hold it until the engine is free.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ibuf_present_q <= s_tuser;
			ibuf_mask_q    <= s_tdata[LEV_LO-1:0];
			ibuf_levels_q  <= s_tdata[NOW_LO-1:LEV_LO];
			ibuf_now_q     <= s_tdata[NOW_LO+TIME_W-1:NOW_LO];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ibuf_valid_q <= 1'b0;
			debounce_q   <= DEBOUNCE_RESET;
			long_press_q <= LONG_PRESS_RESET;
		end else begin
			if (s_tvalid && s_tready) begin
				ibuf_valid_q <= 1'b1;
			end else if (start) begin
				ibuf_valid_q <= 1'b0;
			end
			// Register write decode; drop unknown indexes.
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_DEBOUNCE:   debounce_q   <= cfg_data;
					REG_LONG_PRESS: long_press_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	bdlp_poll_engine u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.expander_present (ibuf_present_q),
		.expander_mask    (ibuf_mask_q),
		.direct_levels    (ibuf_levels_q),
		.now_ms           (ibuf_now_q),
		.debounce_time    (debounce_q),
		.long_press_time  (long_press_q),
		.idle             (eng_idle),
		.hand_valid       (hand_valid),
		.hand             (hand),
		.hand_take        (hand_take)
	);

	bdlp_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.hand_valid (hand_valid),
		.hand       (hand),
		.hand_take  (hand_take),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tlast    (m_tlast),
		.m_kind     (m_tuser),
		.m_id       (ev_id),
		.m_time     (ev_time)
	);

	// Pack the event: id low, time above it, zero fill to whole bytes.
	assign m_tdata = OUT_TDATA_W'({ev_time, ev_id});

endmodule
